// File: rtl/cpu_alu_with_flags_defines.svh
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_defines
// assertion macros used by the alu top level rtl
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CAWF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CAWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cawf_pkg.sv
// ----------------------------------------------------------------------------
// cawf_pkg
// operation codes and item types of the 8/16-bit cpu alu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cawf_pkg;

    localparam int unsigned MODE_W   = 6;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned BIDX_W   = 3;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [MODE_W-1:0] MODE_ADD   = 6'd0;
    localparam logic [MODE_W-1:0] MODE_ADC   = 6'd1;
    localparam logic [MODE_W-1:0] MODE_SUB   = 6'd2;
    localparam logic [MODE_W-1:0] MODE_SBC   = 6'd3;
    localparam logic [MODE_W-1:0] MODE_AND   = 6'd4;
    localparam logic [MODE_W-1:0] MODE_XOR   = 6'd5;
    localparam logic [MODE_W-1:0] MODE_OR    = 6'd6;
    localparam logic [MODE_W-1:0] MODE_CP    = 6'd7;
    localparam logic [MODE_W-1:0] MODE_INC   = 6'd8;
    localparam logic [MODE_W-1:0] MODE_DEC   = 6'd9;
    localparam logic [MODE_W-1:0] MODE_RLCA  = 6'd10;
    localparam logic [MODE_W-1:0] MODE_RRCA  = 6'd11;
    localparam logic [MODE_W-1:0] MODE_RLA   = 6'd12;
    localparam logic [MODE_W-1:0] MODE_RRA   = 6'd13;
    localparam logic [MODE_W-1:0] MODE_DAA   = 6'd14;
    localparam logic [MODE_W-1:0] MODE_CPL   = 6'd15;
    localparam logic [MODE_W-1:0] MODE_SCF   = 6'd16;
    localparam logic [MODE_W-1:0] MODE_CCF   = 6'd17;
    localparam logic [MODE_W-1:0] MODE_RLC   = 6'd18;
    localparam logic [MODE_W-1:0] MODE_RRC   = 6'd19;
    localparam logic [MODE_W-1:0] MODE_RL    = 6'd20;
    localparam logic [MODE_W-1:0] MODE_RR    = 6'd21;
    localparam logic [MODE_W-1:0] MODE_SLA   = 6'd22;
    localparam logic [MODE_W-1:0] MODE_SRA   = 6'd23;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 6'd24;
    localparam logic [MODE_W-1:0] MODE_SRL   = 6'd25;
    localparam logic [MODE_W-1:0] MODE_BIT   = 6'd26;
    localparam logic [MODE_W-1:0] MODE_RES   = 6'd27;
    localparam logic [MODE_W-1:0] MODE_SET   = 6'd28;
    localparam logic [MODE_W-1:0] MODE_ADD16 = 6'd29;
    localparam logic [MODE_W-1:0] MODE_ADDSP = 6'd30;
    localparam logic [MODE_W-1:0] MODE_INC16 = 6'd31;
    localparam logic [MODE_W-1:0] MODE_DEC16 = 6'd32;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [BIDX_W-1:0] bit_index;
        logic              flag_z_in;
        logic              flag_n_in;
        logic              flag_h_in;
        logic              flag_c_in;
    } t_alu_in;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic              flag_z;
        logic              flag_n;
        logic              flag_h;
        logic              flag_c;
    } t_alu_out;

endpackage

// File: rtl/cawf_in_stage.sv
// ----------------------------------------------------------------------------
// cawf_in_stage
// input register: unpacks the slave stream item into the operation struct
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cawf_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [cawf_pkg::MODE_W-1:0]    i_user,
    input  logic [cawf_pkg::S_DATA_W-1:0]  i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output cawf_pkg::t_alu_in              o_item
);
    import cawf_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_alu_in r_item;
    t_alu_in n_item;

    // stage frees up in the same cycle the next stage takes its item
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_ready) begin
            n_valid = i_valid;
        end
        if (o_ready && i_valid) begin
            n_item.mode      = i_user;
            n_item.operand_a = i_data[15:0];
            n_item.operand_b = i_data[31:16];
            n_item.bit_index = i_data[34:32];
            n_item.flag_z_in = i_data[35];
            n_item.flag_n_in = i_data[36];
            n_item.flag_h_in = i_data[37];
            n_item.flag_c_in = i_data[38];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/cawf_alu.sv
// ----------------------------------------------------------------------------
// cawf_alu
// combinational datapath: 8-bit arithmetic, logic, shifts, bit ops, 16-bit adds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cawf_alu (
    input  cawf_pkg::t_alu_in  i_op,
    output cawf_pkg::t_alu_out o_res
);
    import cawf_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic [15:0] a16;
    logic [15:0] b16;
    logic        fz;
    logic        fn;
    logic        fh;
    logic        fc;

    logic [7:0]  add_t;
    logic        add_cin;
    logic [8:0]  add_s;
    logic [8:0]  add_x;
    logic [7:0]  sub_t;
    logic        sub_cin;
    logic [8:0]  sub_s;
    logic [8:0]  sub_x;

    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_t;
    logic [7:0]  daa_r;

    logic [16:0] add16_s;
    logic [15:0] add16_x;
    logic [15:0] sp_r;
    logic [4:0]  sp_lo;
    logic [8:0]  sp_by;

    logic [7:0]  bit_mask;
    logic [7:0]  r8;

    assign a   = i_op.operand_a[7:0];
    assign b   = i_op.operand_b[7:0];
    assign a16 = i_op.operand_a;
    assign b16 = i_op.operand_b;
    assign fz  = i_op.flag_z_in;
    assign fn  = i_op.flag_n_in;
    assign fh  = i_op.flag_h_in;
    assign fc  = i_op.flag_c_in;

    // shared 8-bit adder and subtractor, carries read from the xor of operands and sum
    assign add_t   = (i_op.mode == MODE_INC) ? 8'h01 : b;
    assign add_cin = (i_op.mode == MODE_ADC) && fc;
    assign add_s   = {1'b0, a} + {1'b0, add_t} + {8'h00, add_cin};
    assign add_x   = {1'b0, a} ^ {1'b0, add_t} ^ add_s;

    assign sub_t   = (i_op.mode == MODE_DEC) ? 8'h01 : b;
    assign sub_cin = (i_op.mode == MODE_SBC) && fc;
    assign sub_s   = {1'b0, a} - {1'b0, sub_t} - {8'h00, sub_cin};
    assign sub_x   = {1'b0, a} ^ {1'b0, sub_t} ^ sub_s;

    // decimal adjust from the incoming n, h and c
    assign daa_lo = (!fn && (a[3:0] > 4'h9)) || fh;
    assign daa_hi = (!fn && (a > 8'h99)) || fc;
    assign daa_t  = {1'b0, daa_hi, daa_hi, 2'b00, daa_lo, daa_lo, 1'b0};
    assign daa_r  = fn ? (a - daa_t) : (a + daa_t);

    assign add16_s = {1'b0, a16} + {1'b0, b16};
    assign add16_x = a16 ^ b16 ^ add16_s[15:0];

    // sp plus signed byte: flags come from the unsigned low nibble and low byte
    assign sp_r  = a16 + {{8{b[7]}}, b};
    assign sp_lo = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
    assign sp_by = {1'b0, a16[7:0]} + {1'b0, b};

    assign bit_mask = 8'h01 << i_op.bit_index;

    always_comb begin
        o_res.result = a16;
        o_res.flag_z = fz;
        o_res.flag_n = fn;
        o_res.flag_h = fh;
        o_res.flag_c = fc;
        r8           = 8'h00;
        case (i_op.mode)
            MODE_ADD, MODE_ADC, MODE_INC: begin
                r8           = add_s[7:0];
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = add_x[4];
                if (i_op.mode != MODE_INC) begin
                    o_res.flag_c = add_x[8];
                end
            end
            MODE_SUB, MODE_SBC, MODE_CP, MODE_DEC: begin
                r8           = sub_s[7:0];
                o_res.result = (i_op.mode == MODE_CP) ? a16 : {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b1;
                o_res.flag_h = sub_x[4];
                if (i_op.mode != MODE_DEC) begin
                    o_res.flag_c = sub_x[8];
                end
            end
            MODE_AND, MODE_XOR, MODE_OR: begin
                if (i_op.mode == MODE_AND) begin
                    r8 = a & b;
                end else if (i_op.mode == MODE_XOR) begin
                    r8 = a ^ b;
                end else begin
                    r8 = a | b;
                end
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = (i_op.mode == MODE_AND);
                o_res.flag_c = 1'b0;
            end
            MODE_RLCA, MODE_RLC: begin
                r8           = {a[6:0], a[7]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (i_op.mode == MODE_RLC) && (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[7];
            end
            MODE_RRCA, MODE_RRC: begin
                r8           = {a[0], a[7:1]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (i_op.mode == MODE_RRC) && (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[0];
            end
            MODE_RLA, MODE_RL: begin
                r8           = {a[6:0], fc};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (i_op.mode == MODE_RL) && (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[7];
            end
            MODE_RRA, MODE_RR: begin
                r8           = {fc, a[7:1]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (i_op.mode == MODE_RR) && (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[0];
            end
            MODE_DAA: begin
                r8           = daa_r;
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_h = 1'b0;
                o_res.flag_c = fc || daa_hi;
            end
            MODE_CPL: begin
                r8           = ~a;
                o_res.result = {8'h00, r8};
                o_res.flag_n = 1'b1;
                o_res.flag_h = 1'b1;
            end
            MODE_SCF: begin
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = 1'b1;
            end
            MODE_CCF: begin
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = !fc;
            end
            MODE_SLA: begin
                r8           = {a[6:0], 1'b0};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[7];
            end
            MODE_SRA: begin
                r8           = {a[7], a[7:1]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[0];
            end
            MODE_SWAP: begin
                r8           = {a[3:0], a[7:4]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = 1'b0;
            end
            MODE_SRL: begin
                r8           = {1'b0, a[7:1]};
                o_res.result = {8'h00, r8};
                o_res.flag_z = (r8 == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b0;
                o_res.flag_c = a[0];
            end
            MODE_BIT: begin
                o_res.flag_z = ((a & bit_mask) == 8'h00);
                o_res.flag_n = 1'b0;
                o_res.flag_h = 1'b1;
            end
            MODE_RES: begin
                r8           = a & ~bit_mask;
                o_res.result = {8'h00, r8};
            end
            MODE_SET: begin
                r8           = a | bit_mask;
                o_res.result = {8'h00, r8};
            end
            MODE_ADD16: begin
                o_res.result = add16_s[15:0];
                o_res.flag_n = 1'b0;
                o_res.flag_h = add16_x[12];
                o_res.flag_c = add16_s[16];
            end
            MODE_ADDSP: begin
                o_res.result = sp_r;
                o_res.flag_z = 1'b0;
                o_res.flag_n = 1'b0;
                o_res.flag_h = sp_lo[4];
                o_res.flag_c = sp_by[8];
            end
            MODE_INC16: begin
                o_res.result = a16 + 16'h0001;
            end
            MODE_DEC16: begin
                o_res.result = a16 - 16'h0001;
            end
            default: begin
                // unused codes pass operand and flags through
                o_res.result = a16;
            end
        endcase
    end

endmodule

// File: rtl/cawf_out_stage.sv
// ----------------------------------------------------------------------------
// cawf_out_stage
// result register: holds one result item and packs it onto the master stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cawf_out_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  cawf_pkg::t_alu_out             i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [cawf_pkg::M_DATA_W-1:0]  o_data
);
    import cawf_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_alu_out r_item;
    t_alu_out n_item;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_ready) begin
            n_valid = i_valid;
        end
        if (o_ready && i_valid) begin
            n_item = i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_data  = {4'h0, r_item.flag_c, r_item.flag_h, r_item.flag_n, r_item.flag_z,
                      r_item.result};

endmodule

// File: rtl/cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8/16-bit cpu alu with z/n/h/c flags on stream channels
// ----------------------------------------------------------------------------
// usage:
//   slave channel carries one operation per item: the opcode on i_s_tuser and
//   the operands, bit index and incoming flags on i_s_tdata. master channel
//   returns one item per operation: the result and the four new flags.
//   the path has two register stages: the accepting edge loads the input
//   register and the alu result is then loaded into the result register,
//   which drives o_m_tvalid; a low i_m_tready can hold the item back.
//   throughput is one item per cycle while i_m_tready is high, set by the
//   single alu pass between the registers; each moves on when the next frees up.
//   when i_m_tready is low the result register holds, the input register
//   still takes one more item, and o_s_tready drops only once both are full.
//   reset clears both valid bits; items in flight are dropped and the block
//   is ready again as soon as the valid bits are clear.
//   unused opcodes return operand_a with the flags passed through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_alu_with_flags (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // mode[5:0]
    input  logic [cawf_pkg::MODE_W-1:0]    i_s_tuser,
    // operand_a[15:0], operand_b[31:16], bit_index[34:32], flag_z_in[35],
    // flag_n_in[36], flag_h_in[37], flag_c_in[38], zero[39]
    input  logic [cawf_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // result[15:0], flag_z[16], flag_n[17], flag_h[18], flag_c[19], zero[23:20]
    output logic [cawf_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import cawf_pkg::*;

`include "cpu_alu_with_flags_defines.svh"

    logic     op_valid;
    logic     res_ready;
    t_alu_in  op_item;
    t_alu_out res_item;

    cawf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_user  (i_s_tuser),
        .i_data  (i_s_tdata),
        .o_valid (op_valid),
        .i_ready (res_ready),
        .o_item  (op_item)
    );

    cawf_alu u_alu (
        .i_op  (op_item),
        .o_res (res_item)
    );

    cawf_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (op_valid),
        .o_ready (res_ready),
        .i_item  (res_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata)
    );

    `CAWF_ASSERT_NEXT(a_in_lands, i_s_tvalid && o_s_tready, op_valid,
        "accepted item did not reach the input register")
    `CAWF_ASSERT_NEXT(a_op_moves, op_valid && res_ready, o_m_tvalid,
        "operation did not move into the result register")
    `CAWF_ASSERT_SAME(a_stall_full, !o_s_tready, op_valid && o_m_tvalid,
        "input stalled while a register is empty")
    `CAWF_ASSERT_SAME(a_keep_a, op_valid && (op_item.mode == MODE_BIT || op_item.mode == MODE_CP),
        res_item.result == op_item.operand_a, "bit or cp changed the operand")

endmodule
